@@ design/iesq_pkg.sv @@
// Shared types, codes and helpers for the I2C EEPROM access sequencer.
package iesq_pkg;

   localparam int COUNT_BITS = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int MAX_RESULTS = 3;

   typedef enum logic [1:0] {
      KIND_BEGIN  = 2'd0,
      KIND_WDATA  = 2'd1,
      KIND_ACK    = 2'd2,
      KIND_RXBYTE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_RESTART = 3'd2,
      CMD_STOP    = 3'd3,
      CMD_WRITE   = 3'd4,
      CMD_RX_ACK  = 3'd5,
      CMD_RX_NACK = 3'd6
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_ACK_DEV   = 4'd1,
      PH_ACK_AHI   = 4'd2,
      PH_ACK_ALO   = 4'd3,
      PH_WAIT_DATA = 4'd4,
      PH_ACK_DATA  = 4'd5,
      PH_POLL      = 4'd6,
      PH_ACK_RDEV  = 4'd7,
      PH_RECV      = 4'd8
   } phase_type;

   typedef struct packed {
      cmd_type    bus_command;
      logic [7:0] command_byte;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       done_res;
      logic       success;
      logic       out_of_turn;
   } result_type;

   typedef struct packed {
      logic [1:0]                   rsp_count;
      result_type [MAX_RESULTS-1:0] res;
   } entry_type;

   function automatic result_type mk_result(cmd_type cmd, logic [7:0] cbyte,
                                            logic rv, logic [7:0] rbyte,
                                            logic done, logic ok, logic oot);
      result_type r;
      r.bus_command  = cmd;
      r.command_byte = cbyte;
      r.read_valid   = rv;
      r.read_byte    = rbyte;
      r.done_res     = done;
      r.success      = ok;
      r.out_of_turn  = oot;
      return r;
   endfunction

endpackage

@@ design/iesq_front.sv @@
// Front end: takes request beats, runs the transaction phase machine, queues result groups.
module iesq_front import iesq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  kind_type   kind,
   input  logic       op_read,
   input  logic [7:0] device_id,
   input  logic [15:0] memory_address,
   input  logic [7:0] byte_count,
   input  logic [7:0] data_value,
   input  logic       ack_status,
   output logic       push,
   output entry_type  entry
);

   phase_type             phase_ff, phase_in;
   logic                  is_read_ff, is_read_in;
   logic [7:0]            device_byte_ff, device_byte_in;
   logic [15:0]           address_reg_ff, address_reg_in;
   logic [COUNT_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [COUNT_BITS-1:0] bl_dec;
   logic                  taken;
   logic [1:0]            n;
   result_type            r0, r1, r2;
   result_type            stop_fail, stop_ok, start_r, dev_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         is_read_ff     <= 1'b0;
         device_byte_ff <= 8'd0;
         address_reg_ff <= 16'd0;
         bytes_left_ff  <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         is_read_ff     <= is_read_in;
         device_byte_ff <= device_byte_in;
         address_reg_ff <= address_reg_in;
         bytes_left_ff  <= bytes_left_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      is_read_in     = is_read_ff;
      device_byte_in = device_byte_ff;
      address_reg_in = address_reg_ff;
      bytes_left_in  = bytes_left_ff;
      bl_dec         = bytes_left_ff - COUNT_BITS'(1);
      taken          = 1'b1;
      n              = 2'd0;
      stop_fail = mk_result(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
      stop_ok   = mk_result(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0);
      start_r   = mk_result(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
      dev_wr    = mk_result(CMD_WRITE, device_byte_ff, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
      r0 = '0;
      r1 = '0;
      r2 = '0;
      unique case (phase_ff) inside
         PH_IDLE: begin
            if (kind != KIND_BEGIN) begin
               taken = 1'b0;
            end else begin
               is_read_in     = op_read;
               device_byte_in = {device_id[7:1], 1'b0};
               address_reg_in = memory_address;
               bytes_left_in  = COUNT_BITS'(byte_count);
               r0 = start_r;
               r1 = mk_result(CMD_WRITE, {device_id[7:1], 1'b0}, 1'b0, 8'd0,
                              1'b0, 1'b0, 1'b0);
               n = 2'd2;
               phase_in = PH_ACK_DEV;
            end
         end
         PH_ACK_DEV, PH_ACK_AHI, PH_ACK_ALO, PH_ACK_DATA, PH_ACK_RDEV: begin
            if (kind != KIND_ACK) begin
               taken = 1'b0;
            end else if (ack_status) begin
               r0 = stop_fail;
               n = 2'd1;
               phase_in = PH_IDLE;
            end else if (phase_ff == PH_ACK_DEV) begin
               r0 = mk_result(CMD_WRITE, address_reg_ff[15:8], 1'b0, 8'd0,
                              1'b0, 1'b0, 1'b0);
               n = 2'd1;
               phase_in = PH_ACK_AHI;
            end else if (phase_ff == PH_ACK_AHI) begin
               r0 = mk_result(CMD_WRITE, address_reg_ff[7:0], 1'b0, 8'd0,
                              1'b0, 1'b0, 1'b0);
               n = 2'd1;
               phase_in = PH_ACK_ALO;
            end else if (phase_ff == PH_ACK_ALO && is_read_ff) begin
               r0 = mk_result(CMD_RESTART, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
               r1 = mk_result(CMD_WRITE, {device_byte_ff[7:1], 1'b1}, 1'b0, 8'd0,
                              1'b0, 1'b0, 1'b0);
               n = 2'd2;
               phase_in = PH_ACK_RDEV;
            end else if (phase_ff == PH_ACK_RDEV) begin
               n = 2'd1;
               if (bytes_left_ff == '0) begin
                  r0 = stop_ok;
                  phase_in = PH_IDLE;
               end else begin
                  r0 = mk_result((bytes_left_ff == COUNT_BITS'(1)) ? CMD_RX_NACK
                                 : CMD_RX_ACK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
                  phase_in = PH_RECV;
               end
            end else if (bytes_left_ff == '0) begin
               r0 = mk_result(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
               r1 = start_r;
               r2 = dev_wr;
               n = 2'd3;
               phase_in = PH_POLL;
            end else begin
               phase_in = PH_WAIT_DATA;
            end
         end
         PH_WAIT_DATA: begin
            if (kind != KIND_WDATA) begin
               taken = 1'b0;
            end else begin
               r0 = mk_result(CMD_WRITE, data_value, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
               n = 2'd1;
               bytes_left_in = bl_dec;
               phase_in = PH_ACK_DATA;
            end
         end
         PH_POLL: begin
            if (kind != KIND_ACK) begin
               taken = 1'b0;
            end else if (ack_status) begin
               r0 = mk_result(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
               r1 = start_r;
               r2 = dev_wr;
               n = 2'd3;
            end else begin
               r0 = stop_ok;
               n = 2'd1;
               phase_in = PH_IDLE;
            end
         end
         PH_RECV: begin
            if (kind != KIND_RXBYTE) begin
               taken = 1'b0;
            end else begin
               r0 = mk_result(CMD_NONE, 8'd0, 1'b1, data_value, 1'b0, 1'b0, 1'b0);
               n = 2'd2;
               bytes_left_in = bl_dec;
               if (bl_dec == '0) begin
                  r1 = stop_ok;
                  phase_in = PH_IDLE;
               end else begin
                  r1 = mk_result((bl_dec == COUNT_BITS'(1)) ? CMD_RX_NACK : CMD_RX_ACK,
                                 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
               end
            end
         end
         default: begin
            taken = 1'b0;
         end
      endcase
      if (!taken) begin
         phase_in       = phase_ff;
         is_read_in     = is_read_ff;
         device_byte_in = device_byte_ff;
         address_reg_in = address_reg_ff;
         bytes_left_in  = bytes_left_ff;
         r0 = mk_result(CMD_NONE, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
         r1 = '0;
         r2 = '0;
         n  = 2'd1;
      end
      entry.rsp_count = n;
      entry.res[0]    = r0;
      entry.res[1]    = r1;
      entry.res[2]    = r2;
      push = accept && (n != 2'd0);
   end

   // a finishing stop is always the final result of its group
   assert property (@(posedge clock) disable iff (reset)
      push && entry.res[0].done_res |-> entry.rsp_count == 2'd1)
      else $error("done result not last in group");

endmodule

@@ design/iesq_queue.sv @@
// Short queue of result groups between the front end and the output side.
module iesq_queue import iesq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         count_ff <= count_in;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + (QUEUE_AW+1)'(1);
      if (pop && !push) count_in = count_ff - (QUEUE_AW+1)'(1);
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");

endmodule

@@ design/iesq_back.sv @@
// Output side: walks each queued group and drives one response beat per cycle while rsp_tready is high.
module iesq_back import iesq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  entry_type   head,
   input  logic        empty,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);

   logic        valid_ff;
   logic [1:0]  slot_ff;
   result_type  data_ff, sel;
   logic        last_ff, sel_last, load;

   always_comb begin
      case (slot_ff)
         2'd0:    sel = head.res[0];
         2'd1:    sel = head.res[1];
         default: sel = head.res[2];
      endcase
      sel_last = (slot_ff + 2'd1 == head.rsp_count);
      load     = !empty && (!valid_ff || rsp_tready);
      pop      = load && sel_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            slot_ff  <= sel_last ? 2'd0 : slot_ff + 2'd1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= sel;
         last_ff <= sel_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {1'b0, data_ff.out_of_turn, data_ff.success, data_ff.done_res,
                        data_ff.read_byte, data_ff.read_valid, data_ff.command_byte,
                        data_ff.bus_command};

   assert property (@(posedge clock) disable iff (reset)
      !empty |-> slot_ff < head.rsp_count)
      else $error("slot beyond group size");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.done_res |-> last_ff)
      else $error("done beat not marked last");

endmodule

@@ design/i2c_eeprom_access_sequencer_core.sv @@
// Top level of the I2C EEPROM access sequencer.
// Each request beat (begin, write byte, bus ack status, received byte) is taken
// whenever the four-entry result queue has room, so req_tready drops only when
// four groups wait on the response side. A beat yields zero to three response
// beats; they pass through the queue and then the output register, which sends
// one per cycle while rsp_tready is high, so the response port sets the sustained
// rate at one result per cycle. Beats that do not fit the current phase return one out_of_turn response.
module i2c_eeprom_access_sequencer_core import iesq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op_read, device_id[7:0], memory_address[15:0], byte_count[7:0],
   // data_value[7:0], ack_status, zero fill
   input  logic [47:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // bus_command[2:0], command_byte[7:0], read_valid, read_byte[7:0],
   // done_res, success, out_of_turn, zero fill
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);

   logic      accept, push, pop, empty, full;
   entry_type entry, head;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   iesq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .kind           (kind_type'(req_tuser)),
      .op_read        (req_tdata[0]),
      .device_id      (req_tdata[8:1]),
      .memory_address (req_tdata[24:9]),
      .byte_count     (req_tdata[32:25]),
      .data_value     (req_tdata[40:33]),
      .ack_status     (req_tdata[41]),
      .push           (push),
      .entry          (entry)
   );

   iesq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   iesq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
